// ----- hw/rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// shared types, codes and defaults for the sorted identifier set
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int DEPTH_DEF    = 32;
    localparam int ID_WIDTH_DEF = 32;

    // fixed widths of the external fields
    localparam int ACT_W   = 2;
    localparam int IDENT_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 6;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_ALT    = 2'd3   // handled as find
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp;   // compare stored entry against key
        logic ins;   // open a slot and insert key
        logic del;   // close the slot of the matching entry
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/srt_cell.sv -----
// ----------------------------------------------------------------------------
// srt_cell
// one slot of the sorted chain: holds an entry, compares it, shifts with
// its neighbors on insert and delete
// ----------------------------------------------------------------------------
module srt_cell #(
    parameter int INDEX    = 0,
    parameter int ID_WIDTH = srt_pkg::ID_WIDTH_DEF,
    parameter int CNT_W    = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  srt_pkg::cell_ctrl_t     ctrl,
    input  logic [ID_WIDTH-1:0]     key,
    input  logic [CNT_W-1:0]        count,
    input  logic                    prev_lt,
    input  logic [ID_WIDTH-1:0]     prev_entry,
    input  logic [ID_WIDTH-1:0]     next_entry,
    output logic [ID_WIDTH-1:0]     entry,
    output logic                    lt,
    output logic                    eq
);
    import srt_pkg::*;

    logic [ID_WIDTH-1:0] entry_reg;
    logic [ID_WIDTH-1:0] entry_next;
    logic                lt_reg;
    logic                lt_next;
    logic                eq_reg;
    logic                eq_next;
    logic                occ;

    assign occ = count > CNT_W'(INDEX);

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        entry_next = entry_reg;
        if (ctrl.cmp)
        begin
            lt_next = occ && (entry_reg < key);
            eq_next = occ && (entry_reg == key);
        end
        if (ctrl.ins && !lt_reg)
        begin
            // first slot not below key takes key, the rest move up
            entry_next = prev_lt ? key : prev_entry;
        end
        else if (ctrl.del && !lt_reg)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// ----- hw/rtl/sorted_id_set.sv -----
// ----------------------------------------------------------------------------
// sorted_id_set
// set of distinct identifiers kept in ascending order in a chain of cells
// ----------------------------------------------------------------------------
// The set lives in a row of DEPTH cells, cell 0 holding the smallest entry;
// only the first entry_count cells are meaningful, so no clearing pass is
// needed after reset. Each input transfer (add, remove, find; code 3 acts as
// find) yields exactly one result transfer. An item passes the compare state,
// in which every cell compares its entry with the identifier in parallel, and
// then the update state, in which the cells shift by one toward or away from
// their neighbor to insert or delete, and the result is registered. A new item
// is taken in that update state, so the next item enters while the last one
// finishes. The update state waits while an earlier result has not been taken;
// smallest, largest and entry_count are read straight from the cells and the
// count and stay steady until that result transfer completes.
module sorted_id_set #(
    parameter int DEPTH    = srt_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = srt_pkg::ID_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [srt_pkg::ACT_W-1:0]      action,
    input  logic [srt_pkg::IDENT_W-1:0]    ident,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [srt_pkg::POS_W-1:0]      position,
    output logic                           changed,
    output logic                           full_reject,
    output logic [srt_pkg::COUNT_W-1:0]    entry_count,
    output logic [srt_pkg::IDENT_W-1:0]    smallest,
    output logic [srt_pkg::IDENT_W-1:0]    largest
);
    import srt_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // latched item
    action_t            act_reg;
    logic [ID_WIDTH-1:0] key_reg;

    // result payload
    logic               found_reg;
    logic [POS_W-1:0]   position_reg;
    logic               changed_reg;
    logic               reject_reg;

    // cell chain
    cell_ctrl_t             ctrl;
    logic [ID_WIDTH-1:0]    cell_entry [DEPTH];
    logic [DEPTH-1:0]       cell_lt;
    logic [DEPTH-1:0]       cell_eq;

    // decisions of the update cycle
    logic               upd_go;
    logic               present;
    logic [IDX_W-1:0]   hit_idx;
    logic               is_full;
    logic               do_ins;
    logic               do_del;
    logic               do_reject;
    logic               in_xfer;
    logic [ID_WIDTH-1:0] tail_entry;

    assign upd_go  = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE) || upd_go;
    assign in_xfer  = in_valid && in_ready;

    // one-hot match to index, and the entry sitting at the top of the set
    always_comb
    begin
        present    = 1'b0;
        hit_idx    = '0;
        tail_entry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            present = present | cell_eq[i];
            if (cell_eq[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (count_reg == CNT_W'(i + 1))
            begin
                tail_entry = tail_entry | cell_entry[i];
            end
        end
    end

    assign is_full   = count_reg == CNT_W'(DEPTH);
    assign do_ins    = (act_reg == ACT_ADD) && !present && !is_full;
    assign do_reject = (act_reg == ACT_ADD) && !present && is_full;
    assign do_del    = (act_reg == ACT_REMOVE) && present;

    always_comb
    begin
        ctrl.cmp = state_reg == ST_CMP;
        ctrl.ins = upd_go && do_ins;
        ctrl.del = upd_go && do_del;
    end

    // sequencer: idle -> compare -> update, then back to compare or idle
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    out_valid_next = 1'b1;
                    if (do_ins)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (do_del)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = in_xfer ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg <= action_t'(action);
            key_reg <= ID_WIDTH'(ident);
        end
        if (upd_go)
        begin
            found_reg    <= present;
            position_reg <= present ? POS_W'(hit_idx) : '0;
            changed_reg  <= do_ins || do_del;
            reject_reg   <= do_reject;
        end
    end

    // the chain: each cell sees its lower and upper neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                prev_lt;
        logic [ID_WIDTH-1:0] prev_entry;
        logic [ID_WIDTH-1:0] next_entry;

        if (g == 0)
        begin : g_first
            assign prev_lt    = 1'b1;
            assign prev_entry = '0;
        end
        else
        begin : g_mid
            assign prev_lt    = cell_lt[g-1];
            assign prev_entry = cell_entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_entry = '0;
        end
        else
        begin : g_up
            assign next_entry = cell_entry[g+1];
        end

        srt_cell #(
            .INDEX    (g),
            .ID_WIDTH (ID_WIDTH),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key_reg),
            .count      (count_reg),
            .prev_lt    (prev_lt),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cell_entry[g]),
            .lt         (cell_lt[g]),
            .eq         (cell_eq[g])
        );
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign changed     = changed_reg;
    assign full_reject = reject_reg;
    assign entry_count = COUNT_W'(count_reg);
    assign smallest    = (count_reg != '0) ? IDENT_W'(cell_entry[0]) : '0;
    assign largest     = IDENT_W'(tail_entry);

endmodule

// ----- hw/rtl/srt_checker.sv -----
// ----------------------------------------------------------------------------
// srt_checker
// port-level checks for the sorted identifier set
// ----------------------------------------------------------------------------
module srt_checker #(
    parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           found,
    input logic [srt_pkg::POS_W-1:0]      position,
    input logic                           changed,
    input logic                           full_reject,
    input logic [srt_pkg::COUNT_W-1:0]    entry_count,
    input logic [srt_pkg::IDENT_W-1:0]    smallest,
    input logic [srt_pkg::IDENT_W-1:0]    largest
);
    import srt_pkg::*;

    // a pending result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position)
            && $stable(entry_count) && $stable(smallest) && $stable(largest))
        else $error("result changed while stalled");

    // a refused add never matched and never changed the set
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_reject |-> !found && !changed && position == '0)
        else $error("refused add reports a match or a change");

    // without a match the position reads zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("position set without a match");

    // for DEPTH below 64, an empty set shows zero bounds and keeps order otherwise
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (DEPTH < 64) |->
            ((entry_count == '0) && smallest == '0 && largest == '0)
            || ((entry_count != '0) && smallest <= largest))
        else $error("bounds disagree with the count");

endmodule

bind sorted_id_set srt_checker #(.DEPTH(DEPTH)) u_srt_checker (.*);
